// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== design/ldst_pkg.sv =====
// Shared types and constants of the lattice stencil triplet assembler.
`timescale 1ns / 1ps

package ldst_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int COORD_W   = 6;
  localparam int EXT_W     = 7;
  localparam int SITE_W    = 12;
  localparam int MAT_W     = 13;
  localparam int IDX_W     = 16;
  localparam int CNT_W     = 17;
  localparam int VAL_W     = 4;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 56;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  localparam logic [EXT_W-1:0] COLS_RESET = 7'd8;
  localparam logic [EXT_W-1:0] ROWS_RESET = 7'd8;

  // One classified site pair: which block entries are nonzero and their values.
  typedef struct packed {
    logic [3:0]              mask;
    logic signed [VAL_W-1:0] re_diag;
    logic signed [VAL_W-1:0] re_off;
    logic signed [VAL_W-1:0] im_off;
    logic [SITE_W-1:0]       src_site;
    logic [SITE_W-1:0]       dst_site;
  } item_t;

endpackage

// ===== design/ldst_front.sv =====
// Front end: accepts site pairs, finds neighbor hops and builds the 2x2 block.
`timescale 1ns / 1ps

module ldst_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ldst_pkg::EXT_W-1:0]        cols,
  input  logic [ldst_pkg::EXT_W-1:0]        rows,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ldst_pkg::COORD_W-1:0]      src_col,
  input  logic [ldst_pkg::COORD_W-1:0]      src_row,
  input  logic [ldst_pkg::COORD_W-1:0]      dst_col,
  input  logic [ldst_pkg::COORD_W-1:0]      dst_row,
  output logic                              push,
  output ldst_pkg::item_t                   push_item,
  input  logic                              queue_full
);

  logic            held;
  ldst_pkg::item_t item;
  ldst_pkg::item_t item_next;
  logic            keep_next;

  logic [ldst_pkg::EXT_W-1:0] sc, sr, dc, dr;
  logic [ldst_pkg::EXT_W-1:0] sc_p1, sr_p1, colp, colm, rowp, rowm;
  logic                       in_range, last_col, first_col;
  logic                       cp, cm, rp, rm;
  logic signed [ldst_pkg::VAL_W-1:0] hc, hr, t_rp, t_rm;
  logic [ldst_pkg::MAT_W-1:0] nsrc, ndst;

  always_comb begin
    sc = {1'b0, src_col};
    sr = {1'b0, src_row};
    dc = {1'b0, dst_col};
    dr = {1'b0, dst_row};
    in_range = (sc < cols) && (sr < rows) && (dc < cols) && (dr < rows);
    sc_p1 = sc + 7'd1;
    sr_p1 = sr + 7'd1;
    last_col  = (sc_p1 == cols);
    first_col = (sc == '0);
    colp = last_col ? '0 : sc_p1;
    colm = first_col ? cols - 7'd1 : sc - 7'd1;
    rowp = (sr_p1 == rows) ? '0 : sr_p1;
    rowm = (sr == '0) ? rows - 7'd1 : sr - 7'd1;

    cp = (dr == sr) && (dc == colp);
    cm = (dr == sr) && (dc == colm);
    rp = (dc == sc) && (dr == rowp);
    rm = (dc == sc) && (dr == rowm);

    // antiperiodic in the column direction: flip the sign on a boundary hop
    hc   = cp ? (last_col ? -4'sd1 : 4'sd1) : 4'sd0;
    hr   = cm ? (first_col ? -4'sd1 : 4'sd1) : 4'sd0;
    t_rp = rp ? 4'sd1 : 4'sd0;
    t_rm = rm ? 4'sd1 : 4'sd0;

    nsrc = ldst_pkg::MAT_W'(src_row) * ldst_pkg::MAT_W'(cols)
         + ldst_pkg::MAT_W'(src_col);
    ndst = ldst_pkg::MAT_W'(dst_row) * ldst_pkg::MAT_W'(cols)
         + ldst_pkg::MAT_W'(dst_col);

    item_next.re_diag  = -hc - hr - t_rp - t_rm;
    item_next.re_off   = -hc + hr;
    item_next.im_off   = t_rp - t_rm;
    item_next.src_site = nsrc[ldst_pkg::SITE_W-1:0];
    item_next.dst_site = ndst[ldst_pkg::SITE_W-1:0];
    item_next.mask[0]  = (item_next.re_diag != 4'sd0);
    item_next.mask[1]  = (item_next.re_off != 4'sd0) || (item_next.im_off != 4'sd0);
    item_next.mask[2]  = item_next.mask[1];
    item_next.mask[3]  = item_next.mask[0];
    keep_next = in_range && (item_next.mask != 4'b0000);
  end

  assign push      = held && !queue_full;
  assign push_item = item;
  assign in_ready  = !held || !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= keep_next;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== design/ldst_queue.sv =====
// Short queue between front and back ends.
`timescale 1ns / 1ps

module ldst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ldst_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ldst_pkg::item_t head
);

  ldst_pkg::item_t              slots [ldst_pkg::QUEUE_DEPTH];
  logic [ldst_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ldst_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ldst_pkg::QPTR_W:0]    count;

  assign full  = (count == (ldst_pkg::QPTR_W+1)'(ldst_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/ldst_back.sv =====
// Back end: walks the nonzero block entries and emits one triplet per cycle while out_ready is high.
`timescale 1ns / 1ps

module ldst_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                empty,
  input  ldst_pkg::item_t                     head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ldst_pkg::IDX_W-1:0]          entry_index,
  output logic [ldst_pkg::MAT_W-1:0]          matrix_row,
  output logic [ldst_pkg::MAT_W-1:0]          matrix_col,
  output logic signed [ldst_pkg::VAL_W-1:0]   real_halves,
  output logic signed [ldst_pkg::VAL_W-1:0]   imag_halves,
  output logic                                last_of_run
);

  logic [3:0]                 done;
  logic [3:0]                 remain;
  logic [3:0]                 sel;
  logic [1:0]                 k;
  logic                       last;
  logic                       load;
  logic [ldst_pkg::CNT_W-1:0] entry_count;
  logic signed [ldst_pkg::VAL_W-1:0] re_sel, im_sel;

  always_comb begin
    remain = head.mask & ~done;
    if (remain[0]) begin
      sel = 4'b0001;
      k   = 2'd0;
    end else if (remain[1]) begin
      sel = 4'b0010;
      k   = 2'd1;
    end else if (remain[2]) begin
      sel = 4'b0100;
      k   = 2'd2;
    end else begin
      sel = 4'b1000;
      k   = 2'd3;
    end
    last = ((remain & ~sel) == 4'b0000);
    case (k)
      2'd1: begin
        re_sel = head.re_off;
        im_sel = head.im_off;
      end
      2'd2: begin
        re_sel = head.re_off;
        im_sel = -head.im_off;
      end
      default: begin
        re_sel = head.re_diag;
        im_sel = 4'sd0;
      end
    endcase
  end

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= '0;
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (load) begin
        done        <= last ? 4'b0000 : (done | sel);
        entry_count <= entry_count + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_index <= entry_count[ldst_pkg::IDX_W-1:0];
      matrix_row  <= {head.src_site, k[1]};
      matrix_col  <= {head.dst_site, k[0]};
      real_halves <= re_sel;
      imag_halves <= im_sel;
      last_of_run <= last;
    end
  end

endmodule

// ===== design/lattice_dirac_stencil_triplets.sv =====
// Top level of the 2D Wilson-Dirac stencil triplet assembler.
//
//  channel  | direction | transfer on           | payload
//  s_*      | in        | s_tvalid & s_tready   | tdata: src_col, src_row, dst_col, dst_row
//  m_*      | out       | m_tvalid & m_tready   | tdata: entry, row, col, re, im; tlast
//  cfg_*    | in        | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// A site pair is taken every cycle while the front register can move on; pairs
// with no nonzero entry, or out of extent, leave nothing behind them.
// A pair with n nonzero entries (n is 2 or 4) holds the back end for n triplets,
// one per cycle out of the output register while m_tready is high; a two-entry
// queue between the front and output registers decouples the two halves.
// Reset clears the entry counter, the queue and restores both extents to 8.
`timescale 1ns / 1ps

module lattice_dirac_stencil_triplets #(
  parameter int MAX_COLS = ldst_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ldst_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // src_col [5:0], src_row [11:6], dst_col [17:12], dst_row [23:18]
  input  logic [ldst_pkg::IN_W-1:0]          s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // entry_index [15:0], matrix_row [28:16], matrix_col [41:29],
  // real_halves [45:42], imag_halves [49:46], zero [55:50]
  output logic [ldst_pkg::OUT_W-1:0]         m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ldst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ldst_pkg::EXT_W-1:0]         cfg_data
);

  logic [ldst_pkg::EXT_W-1:0] lattice_cols;
  logic [ldst_pkg::EXT_W-1:0] lattice_rows;
  logic [ldst_pkg::EXT_W-1:0] cols_eff;
  logic [ldst_pkg::EXT_W-1:0] rows_eff;

  logic            push, queue_full, pop, queue_empty;
  ldst_pkg::item_t push_item, head;

  logic [ldst_pkg::IDX_W-1:0]        entry_index;
  logic [ldst_pkg::MAT_W-1:0]        matrix_row, matrix_col;
  logic signed [ldst_pkg::VAL_W-1:0] real_halves, imag_halves;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_cols <= ldst_pkg::COLS_RESET;
      lattice_rows <= ldst_pkg::ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ldst_pkg::REG_COLS: lattice_cols <= cfg_data;
        ldst_pkg::REG_ROWS: lattice_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // extents above the supported size are used as that size
  assign cols_eff = (32'(lattice_cols) > 32'(MAX_COLS)) ?
                    ldst_pkg::EXT_W'(MAX_COLS) : lattice_cols;
  assign rows_eff = (32'(lattice_rows) > 32'(MAX_ROWS)) ?
                    ldst_pkg::EXT_W'(MAX_ROWS) : lattice_rows;

  ldst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cols       (cols_eff),
    .rows       (rows_eff),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .src_col    (s_tdata[5:0]),
    .src_row    (s_tdata[11:6]),
    .dst_col    (s_tdata[17:12]),
    .dst_row    (s_tdata[23:18]),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  ldst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  ldst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .entry_index (entry_index),
    .matrix_row  (matrix_row),
    .matrix_col  (matrix_col),
    .real_halves (real_halves),
    .imag_halves (imag_halves),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {6'b0, imag_halves, real_halves, matrix_col, matrix_row, entry_index};

endmodule

// ===== design/ldst_checker.sv =====
// Port-level checker for the stencil triplet assembler, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ldst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ldst_pkg::OUT_W-1:0]        m_tdata,
  input logic                              m_tlast,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  // a stalled triplet holds still
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // a run is never split by a gap: the next triplet follows at once
  `ASSERT_CLK(a_run_gapless, clk, rst, m_tvalid && m_tready && !m_tlast |=> m_tvalid)

  // imaginary parts only appear off the spin diagonal
  `ASSERT_CLK(a_imag_offdiag, clk, rst, m_tvalid && (m_tdata[49:46] != 4'b0000) |-> m_tdata[16] != m_tdata[29])

  // register writes are never stalled
  `ASSERT_CLK(a_cfg_ready, clk, rst, cfg_valid |-> cfg_ready)

  // nothing leaves the block right after reset
  `ASSERT_CLK_ALWAYS(a_reset_quiet, clk, rst |=> !m_tvalid)

endmodule

bind lattice_dirac_stencil_triplets ldst_checker u_ldst_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ===== sim/tb_top.sv =====
// Testbench for the lattice stencil triplet assembler: directed and random site pairs.
`timescale 1ns / 1ps

module tb_top;

  // Register indexes with no register behind them; writes must be dropped.
  localparam logic [ldst_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [ldst_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  localparam int DRAIN_CYCLES = 12;
  localparam int STUCK_LIMIT  = 5000;

  typedef enum int {HOP_COL_UP, HOP_COL_DN, HOP_ROW_UP, HOP_ROW_DN} hop_t;

  // Packed so that src_col lands in the lowest bits of s_tdata.
  typedef struct packed {
    logic [ldst_pkg::COORD_W-1:0] dst_row;
    logic [ldst_pkg::COORD_W-1:0] dst_col;
    logic [ldst_pkg::COORD_W-1:0] src_row;
    logic [ldst_pkg::COORD_W-1:0] src_col;
  } site_pair_t;

  typedef struct {
    logic [ldst_pkg::IDX_W-1:0]        entry;
    logic [ldst_pkg::MAT_W-1:0]        mrow;
    logic [ldst_pkg::MAT_W-1:0]        mcol;
    logic signed [ldst_pkg::VAL_W-1:0] re;
    logic signed [ldst_pkg::VAL_W-1:0] im;
    logic [5:0]                        pad;
    logic                              last;
  } triplet_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ldst_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ldst_pkg::OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ldst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ldst_pkg::EXT_W-1:0] cfg_data = '0;

  lattice_dirac_stencil_triplets dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the block's state
  logic [ldst_pkg::EXT_W-1:0] cols_reg = ldst_pkg::COLS_RESET;
  logic [ldst_pkg::EXT_W-1:0] rows_reg = ldst_pkg::ROWS_RESET;
  logic [ldst_pkg::CNT_W-1:0] entry_count = '0;
  triplet_t expected_triplets[$];

  int failures = 0;
  int stuck_cycles = 0;

  // Stream pacing
  bit tx_idle_en = 1'b0;
  bit rx_stall_en = 1'b0;
  bit tx_hold = 1'b0;
  bit cfg_hold = 1'b0;
  int burst_left = 1;
  int rx_left = 0;

  function automatic int eff_cols();
    return (cols_reg > ldst_pkg::MAX_COLS_DEF) ? ldst_pkg::MAX_COLS_DEF : int'(cols_reg);
  endfunction

  function automatic int eff_rows();
    return (rows_reg > ldst_pkg::MAX_ROWS_DEF) ? ldst_pkg::MAX_ROWS_DEF : int'(rows_reg);
  endfunction

  function automatic site_pair_t mk_pair(int sc, int sr, int dc, int dr);
    site_pair_t p;
    p.src_col = ldst_pkg::COORD_W'(sc);
    p.src_row = ldst_pkg::COORD_W'(sr);
    p.dst_col = ldst_pkg::COORD_W'(dc);
    p.dst_row = ldst_pkg::COORD_W'(dr);
    return p;
  endfunction

  // Works out the nonzero spin-block entries of one site pair and queues them.
  function automatic void predict_triplets(site_pair_t p);
    int cols, rows, sc, sr, dc, dr;
    int colp, colm, rowp, rowm;
    int cp, cm, rp, rm, sp, sm, hc, hr;
    int nsrc, ndst, k, j, n;
    int re_v[4];
    int im_v[4];
    triplet_t hits[4];
    cols = eff_cols();
    rows = eff_rows();
    sc = int'(p.src_col);
    sr = int'(p.src_row);
    dc = int'(p.dst_col);
    dr = int'(p.dst_row);
    if (sc >= cols || sr >= rows || dc >= cols || dr >= rows) return;

    colp = (sc + 1 == cols) ? 0 : sc + 1;
    colm = (sc == 0) ? cols - 1 : sc - 1;
    rowp = (sr + 1 == rows) ? 0 : sr + 1;
    rowm = (sr == 0) ? rows - 1 : sr - 1;
    cp = (dr == sr && dc == colp) ? 1 : 0;
    cm = (dr == sr && dc == colm) ? 1 : 0;
    rp = (dc == sc && dr == rowp) ? 1 : 0;
    rm = (dc == sc && dr == rowm) ? 1 : 0;
    // antiperiodic in the column direction
    sp = (sc + 1 == cols) ? -1 : 1;
    sm = (sc == 0) ? -1 : 1;
    hc = sp * cp;
    hr = sm * cm;
    re_v[0] = -hc - hr - rp - rm;  im_v[0] = 0;
    re_v[1] = -hc + hr;            im_v[1] = rp - rm;
    re_v[2] = -hc + hr;            im_v[2] = rm - rp;
    re_v[3] = -hc - hr - rp - rm;  im_v[3] = 0;
    nsrc = sr * cols + sc;
    ndst = dr * cols + dc;

    n = 0;
    for (k = 0; k < 4; k++) begin
      if (re_v[k] != 0 || im_v[k] != 0) begin
        hits[n].entry = entry_count[ldst_pkg::IDX_W-1:0];
        hits[n].mrow  = ldst_pkg::MAT_W'(2 * nsrc + k / 2);
        hits[n].mcol  = ldst_pkg::MAT_W'(2 * ndst + k % 2);
        hits[n].re    = ldst_pkg::VAL_W'(re_v[k]);
        hits[n].im    = ldst_pkg::VAL_W'(im_v[k]);
        hits[n].pad   = '0;
        hits[n].last  = 1'b0;
        entry_count = entry_count + 1'b1;
        n++;
      end
    end
    for (j = 0; j < n; j++) begin
      hits[j].last = (j == n - 1);
      expected_triplets.push_back(hits[j]);
    end
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // Result checker
  triplet_t got_t, want_t;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_t.entry = m_tdata[15:0];
      got_t.mrow  = m_tdata[28:16];
      got_t.mcol  = m_tdata[41:29];
      got_t.re    = m_tdata[45:42];
      got_t.im    = m_tdata[49:46];
      got_t.pad   = m_tdata[55:50];
      got_t.last  = m_tlast;
      if (expected_triplets.size() == 0) begin
        note_failure($sformatf("unexpected triplet idx=%0d row=%0d col=%0d",
                               got_t.entry, got_t.mrow, got_t.mcol));
      end else begin
        want_t = expected_triplets.pop_front();
        if (got_t.entry != want_t.entry || got_t.mrow != want_t.mrow ||
            got_t.mcol != want_t.mcol || got_t.re != want_t.re ||
            got_t.im != want_t.im || got_t.pad != want_t.pad ||
            got_t.last != want_t.last) begin
          note_failure($sformatf({
            "mismatch: exp idx=%0d row=%0d col=%0d re=%0d im=%0d pad=%0d last=%0b",
            " | got idx=%0d row=%0d col=%0d re=%0d im=%0d pad=%0d last=%0b"},
            want_t.entry, want_t.mrow, want_t.mcol, want_t.re, want_t.im, want_t.pad,
            want_t.last, got_t.entry, got_t.mrow, got_t.mcol, got_t.re, got_t.im,
            got_t.pad, got_t.last));
        end
      end
    end
  end

  // Receiver stall pattern: ready runs and stall runs of random length
  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (!rx_stall_en || !m_tready) begin
      m_tready <= 1'b1;
      rx_left <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b0;
      rx_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic release_cfg();
    if (cfg_hold) begin
      cfg_valid <= 1'b0;
      cfg_hold = 1'b0;
    end
  endtask

  task automatic release_stream();
    if (tx_hold) begin
      s_tvalid <= 1'b0;
      tx_hold = 1'b0;
    end
  endtask

  // Valid stays up across a burst; a gap lowers it.
  task automatic send_pair(site_pair_t p);
    release_cfg();
    s_tdata <= p;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_triplets(p);
    tx_hold = 1'b1;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (tx_idle_en) begin
        s_tvalid <= 1'b0;
        tx_hold = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Drain all triplets, then let any result-free pair clear the pipeline.
  task automatic settle();
    release_stream();
    release_cfg();
    while (expected_triplets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ldst_pkg::CFG_IDX_W-1:0] idx,
                           logic [ldst_pkg::EXT_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_hold = 1'b1;
    case (idx)
      ldst_pkg::REG_COLS: cols_reg = val;
      ldst_pkg::REG_ROWS: rows_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_extents(int cols, int rows);
    settle();
    write_reg(ldst_pkg::REG_COLS, ldst_pkg::EXT_W'(cols));
    write_reg(ldst_pkg::REG_ROWS, ldst_pkg::EXT_W'(rows));
  endtask

  function automatic void randomize_pacing();
    tx_idle_en = ($urandom_range(0, 3) != 0);
    rx_stall_en = ($urandom_range(0, 3) != 0);
  endfunction

  // Mostly true neighbours with random content; the rest is noise.
  function automatic site_pair_t random_pair();
    int cols, rows, sc, sr, dc, dr, pick;
    hop_t hop;
    cols = eff_cols();
    rows = eff_rows();
    pick = $urandom_range(0, 9);
    if (cols == 0 || rows == 0 || pick == 8)
      return mk_pair($urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 63));
    sc = $urandom_range(0, cols - 1);
    sr = $urandom_range(0, rows - 1);
    dc = sc;
    dr = sr;
    if (pick <= 6) begin
      hop = hop_t'($urandom_range(0, 3));
      case (hop)
        HOP_COL_UP: dc = (sc + 1 == cols) ? 0 : sc + 1;
        HOP_COL_DN: dc = (sc == 0) ? cols - 1 : sc - 1;
        HOP_ROW_UP: dr = (sr + 1 == rows) ? 0 : sr + 1;
        HOP_ROW_DN: dr = (sr == 0) ? rows - 1 : sr - 1;
      endcase
    end else if (pick == 7) begin
      dc = $urandom_range(0, cols - 1);
      dr = $urandom_range(0, rows - 1);
    end else begin
      // one coordinate pushed to or past its extent
      case ($urandom_range(0, 3))
        0: sc = $urandom_range(cols, 63);
        1: sr = $urandom_range(rows, 63);
        2: dc = $urandom_range(cols, 63);
        default: dr = $urandom_range(rows, 63);
      endcase
      if (cols == ldst_pkg::MAX_COLS_DEF && rows == ldst_pkg::MAX_ROWS_DEF) dc = sc;
    end
    return mk_pair(sc, sr, dc, dr);
  endfunction

  task automatic test_hops_default_extent();
    tx_idle_en = 1'b1;
    rx_stall_en = 1'b1;
    set_extents(int'(ldst_pkg::COLS_RESET), int'(ldst_pkg::ROWS_RESET));
    send_pair(mk_pair(0, 0, 1, 0));   // column up from the left edge
    send_pair(mk_pair(0, 0, 7, 0));   // column down across the boundary
    send_pair(mk_pair(7, 3, 0, 3));   // column up across the boundary
    send_pair(mk_pair(7, 3, 6, 3));
    send_pair(mk_pair(3, 0, 3, 7));   // row down, wrapped
    send_pair(mk_pair(3, 7, 3, 0));   // row up, wrapped
    send_pair(mk_pair(4, 4, 4, 5));
    send_pair(mk_pair(4, 4, 4, 3));
    send_pair(mk_pair(2, 2, 2, 2));   // same site
    send_pair(mk_pair(0, 0, 0, 0));
    send_pair(mk_pair(2, 2, 3, 3));   // diagonal
    send_pair(mk_pair(0, 0, 4, 4));
    send_pair(mk_pair(8, 0, 0, 0));   // out of extent, each field
    send_pair(mk_pair(0, 8, 0, 0));
    send_pair(mk_pair(0, 0, 8, 0));
    send_pair(mk_pair(0, 0, 0, 8));
    send_pair(mk_pair(63, 63, 63, 63));
    send_pair(mk_pair(63, 0, 0, 0));
  endtask

  task automatic test_largest_extent();
    set_extents(ldst_pkg::MAX_COLS_DEF, ldst_pkg::MAX_ROWS_DEF);
    send_pair(mk_pair(63, 63, 0, 63));
    send_pair(mk_pair(0, 63, 63, 63));
    send_pair(mk_pair(63, 63, 63, 0));
    send_pair(mk_pair(63, 0, 63, 63));
    // register beyond the maximum clamps to it
    set_extents(127, 127);
    send_pair(mk_pair(63, 63, 0, 63));
    send_pair(mk_pair(63, 63, 63, 62));
  endtask

  task automatic test_random_extents();
    int cols_set[10] = '{8, 1, 1, 2, 2, 3, 64, 127, 64, 1};
    int rows_set[10] = '{8, 1, 2, 1, 2, 3, 64, 100, 1, 64};
    int ph, i;
    for (ph = 0; ph < 14; ph++) begin
      if (ph < 10) set_extents(cols_set[ph], rows_set[ph]);
      else set_extents($urandom_range(0, 127), $urandom_range(1, 127));
      randomize_pacing();
      for (i = 0; i < 24; i++) send_pair(random_pair());
    end
  endtask

  task automatic test_zero_extent();
    int i;
    set_extents(0, 5);
    randomize_pacing();
    for (i = 0; i < 10; i++) send_pair(random_pair());
    set_extents(5, 0);
    for (i = 0; i < 10; i++) send_pair(random_pair());
    // back to a live setting to show nothing was counted
    set_extents(4, 4);
    for (i = 0; i < 10; i++) send_pair(random_pair());
  endtask

  task automatic test_unmapped_registers();
    int i;
    set_extents(5, 6);
    write_reg(REG_SPARE2, 7'h7F);
    write_reg(REG_SPARE3, ldst_pkg::EXT_W'($urandom_range(0, 127)));
    write_reg(REG_SPARE2, 7'h00);
    randomize_pacing();
    for (i = 0; i < 20; i++) send_pair(random_pair());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hops_default_extent();
    test_largest_extent();
    test_random_extents();
    test_zero_extent();
    test_unmapped_registers();
    settle();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
